### rtl/core/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types, constants and tables for the shape pair gap and normal block.
// ----------------------------------------------------------------------------
package spg_pkg;

  // datapath width of the CORDIC units and gain stages
  localparam int CW = 36;
  // gap working width before saturation
  localparam int GW = 40;
  localparam int PRE_STAGES = 4;
  localparam int ATAN_ENTRIES = 30;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF = 4;

  localparam logic [1:0] MODE_CC = 2'd0;
  localparam logic [1:0] MODE_BC = 2'd1;
  localparam logic [1:0] MODE_CB = 2'd2;
  localparam logic [1:0] MODE_BB = 2'd3;

  typedef logic signed [CW-1:0] cw_t;

  localparam cw_t HALF_PI_Q30 = cw_t'(64'sd1686629713);
  localparam cw_t INV_GAIN_Q30 = cw_t'(64'sd652032874);
  localparam logic [31:0] INV_GAIN_Q32 = 32'd2608131496;

  // one classified pair, as it waits in the queue
  typedef struct packed {
    logic [1:0]         mode;
    logic signed [32:0] dx;     // b - a, or box to circle centre offset
    logic signed [32:0] dy;
    logic signed [18:0] q;      // box angle for box-circle
    logic [29:0]        hx;     // box half extents for box-circle
    logic [29:0]        hy;
    logic [31:0]        rsum;   // radius sum or circle radius
    logic signed [18:0] aq;
    logic signed [18:0] bq;
    logic [29:0]        ahw;
    logic [29:0]        ahh;
    logic [29:0]        bhw;
    logic [29:0]        bhh;
  } item_t;

  // item plus results gathered along the back pipeline
  typedef struct packed {
    item_t              it;
    cw_t                ang_a;
    cw_t                len_a;
    cw_t                zl;
    cw_t                ang_u;
    cw_t                ang_p;
    logic               dflt;
    logic signed [GW-3:0] gbase;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
  } ctx_t;

  function automatic logic [29:0] atan_q30(input int i);
    logic [29:0] r;
    case (i)
      0: r = 30'd843314857;
      1: r = 30'd497837829;
      2: r = 30'd263043837;
      3: r = 30'd133525159;
      4: r = 30'd67021687;
      5: r = 30'd33543516;
      6: r = 30'd16775851;
      7: r = 30'd8388437;
      8: r = 30'd4194283;
      9: r = 30'd2097149;
      10: r = 30'd1048576;
      11: r = 30'd524288;
      12: r = 30'd262144;
      13: r = 30'd131072;
      14: r = 30'd65536;
      15: r = 30'd32768;
      16: r = 30'd16384;
      17: r = 30'd8192;
      18: r = 30'd4096;
      19: r = 30'd2048;
      20: r = 30'd1024;
      21: r = 30'd512;
      22: r = 30'd256;
      23: r = 30'd128;
      24: r = 30'd64;
      25: r = 30'd32;
      26: r = 30'd16;
      27: r = 30'd8;
      28: r = 30'd4;
      29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Q3.16 angle to Q6.30
  function automatic cw_t to_q30(input logic signed [18:0] a);
    return {{(CW-33){a[18]}}, a, 14'd0};
  endfunction

endpackage

### rtl/core/spg_fifo.sv
// ----------------------------------------------------------------------------
// spg_fifo
// Short queue of classified pairs between the front and back parts.
// ----------------------------------------------------------------------------
module spg_fifo #(
  parameter int DEPTH = spg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr,
  input  spg_pkg::item_t wdata,
  input  logic           rd,
  output spg_pkg::item_t rdata,
  output logic           full,
  output logic           empty
);
  import spg_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  item_t          mem [DEPTH];
  logic [AW-1:0]  wptr;
  logic [AW-1:0]  rptr;
  logic [NW-1:0]  count;

  assign full  = (count == NW'(DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) begin
        wptr <= (wptr == AW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (rd) begin
        rptr <= (rptr == AW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (wr && !rd) begin
        count <= count + 1'b1;
      end else if (!wr && rd) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH)) else $error("queue count beyond depth");
  a_no_read_empty: assert property (@(posedge clk) disable iff (rst)
    rd |-> !empty) else $error("queue read while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (wr && !rd) |=> count == $past(count) + 1'b1) else $error("queue count slip");
`endif

endmodule

### rtl/core/spg_front.sv
// ----------------------------------------------------------------------------
// spg_front
// Accepts pairs, sorts them by kind and forms the offsets the back part needs.
// ----------------------------------------------------------------------------
module spg_front (
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [295:0]   s_tdata,
  input  logic [1:0]     s_tuser,
  input  logic           full,
  output logic           push,
  output spg_pkg::item_t item
);
  import spg_pkg::*;

  logic signed [31:0] ax, ay, bx, by;
  logic signed [18:0] aq, bq;
  logic [30:0]        asx, asy, bsx, bsy;

  assign ax  = s_tdata[31:0];
  assign ay  = s_tdata[63:32];
  assign aq  = s_tdata[82:64];
  assign asx = s_tdata[113:83];
  assign asy = s_tdata[144:114];
  assign bx  = s_tdata[176:145];
  assign by  = s_tdata[208:177];
  assign bq  = s_tdata[227:209];
  assign bsx = s_tdata[258:228];
  assign bsy = s_tdata[289:259];

  assign s_tready = !full;
  assign push     = s_tvalid && !full;

  always_comb begin
    item.mode = s_tuser;
    item.aq   = aq;
    item.bq   = bq;
    item.ahw  = asx[30:1];
    item.ahh  = asy[30:1];
    item.bhw  = bsx[30:1];
    item.bhh  = bsy[30:1];
    item.dx   = 33'(bx) - 33'(ax);
    item.dy   = 33'(by) - 33'(ay);
    item.q    = aq;
    item.hx   = asx[30:1];
    item.hy   = asy[30:1];
    item.rsum = {1'b0, asx} + {1'b0, bsx};
    unique case (s_tuser)
      MODE_BC: begin
        item.rsum = {1'b0, bsx};
      end
      MODE_CB: begin
        // box is the second shape: swap roles
        item.dx   = 33'(ax) - 33'(bx);
        item.dy   = 33'(ay) - 33'(by);
        item.q    = bq;
        item.hx   = bsx[30:1];
        item.hy   = bsy[30:1];
        item.rsum = {1'b0, asx};
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/core/spg_cordic.sv
// ----------------------------------------------------------------------------
// spg_cordic
// Pipelined CORDIC, rotation or vectoring: fold stages, then one micro-rotation per step stage.
// ----------------------------------------------------------------------------
module spg_cordic #(
  parameter int STEPS  = spg_pkg::CORDIC_STEPS_DEF,
  parameter bit VECTOR = 1'b0
) (
  input  logic         clk,
  input  logic         en,
  input  spg_pkg::cw_t x_in,
  input  spg_pkg::cw_t y_in,
  input  spg_pkg::cw_t z_in,
  output spg_pkg::cw_t x_out,
  output spg_pkg::cw_t y_out,
  output spg_pkg::cw_t z_out
);
  import spg_pkg::*;

  localparam int L = PRE_STAGES + STEPS;

  cw_t xs [L];
  cw_t ys [L];
  cw_t zs [L];

  for (genvar p = 0; p < PRE_STAGES; p++) begin : g_pre
    cw_t xi, yi, zi, xo, yo, zo;
    if (p == 0) begin : g_first
      assign xi = x_in;
      assign yi = y_in;
      assign zi = z_in;
    end else begin : g_next
      assign xi = xs[p-1];
      assign yi = ys[p-1];
      assign zi = zs[p-1];
    end
    always_comb begin
      xo = xi;
      yo = yi;
      zo = zi;
      if (VECTOR) begin
        // bring the vector into the right half plane
        if (p == 0 && xi < 0) begin
          if (yi >= 0) begin
            xo = yi;
            yo = -xi;
            zo = HALF_PI_Q30;
          end else begin
            xo = -yi;
            yo = xi;
            zo = -HALF_PI_Q30;
          end
        end
      end else begin
        // quarter-turn fold
        if (zi > HALF_PI_Q30) begin
          xo = -yi;
          yo = xi;
          zo = zi - HALF_PI_Q30;
        end else if (zi < -HALF_PI_Q30) begin
          xo = yi;
          yo = -xi;
          zo = zi + HALF_PI_Q30;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        xs[p] <= xo;
        ys[p] <= yo;
        zs[p] <= zo;
      end
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_step
    cw_t xi, yi, zi, xsh, ysh, at;
    assign xi  = xs[PRE_STAGES+i-1];
    assign yi  = ys[PRE_STAGES+i-1];
    assign zi  = zs[PRE_STAGES+i-1];
    assign xsh = xi >>> i;
    assign ysh = yi >>> i;
    assign at  = {{(CW-30){1'b0}}, atan_q30(i)};
    always_ff @(posedge clk) begin
      if (en) begin
        if (VECTOR ? (yi > 0) : (zi < 0)) begin
          xs[PRE_STAGES+i] <= xi + ysh;
          ys[PRE_STAGES+i] <= yi - xsh;
          zs[PRE_STAGES+i] <= zi + at;
        end else begin
          xs[PRE_STAGES+i] <= xi - ysh;
          ys[PRE_STAGES+i] <= yi + xsh;
          zs[PRE_STAGES+i] <= zi - at;
        end
      end
    end
  end

  assign x_out = xs[L-1];
  assign y_out = ys[L-1];
  assign z_out = zs[L-1];

endmodule

### rtl/core/spg_gain.sv
// ----------------------------------------------------------------------------
// spg_gain
// Two-stage removal of the CORDIC gain, rounded half away from zero.
// ----------------------------------------------------------------------------
module spg_gain (
  input  logic         clk,
  input  logic         en,
  input  spg_pkg::cw_t v_in,
  output spg_pkg::cw_t v_out
);
  import spg_pkg::*;

  logic [CW-1:0]  mag;
  logic [47:0]    pl_full;
  logic           neg;
  logic [CW+15:0] ph;
  logic [31:0]    pl;
  logic [CW+16:0] sum;
  logic [CW-1:0]  r;

  assign mag     = v_in[CW-1] ? CW'(-v_in) : CW'(v_in);
  assign pl_full = mag[15:0] * INV_GAIN_Q32;

  always_ff @(posedge clk) begin
    if (en) begin
      neg <= v_in[CW-1];
      ph  <= (CW+16)'(mag[CW-1:16]) * (CW+16)'(INV_GAIN_Q32);
      pl  <= pl_full[47:16];
    end
  end

  assign sum = (CW+17)'(ph) + (CW+17)'(pl) + (CW+17)'(32768);
  assign r   = sum[CW+15:16];

  always_ff @(posedge clk) begin
    if (en) begin
      v_out <= neg ? cw_t'(~r + 1'b1) : cw_t'(r);
    end
  end

endmodule

### rtl/core/spg_back.sv
// ----------------------------------------------------------------------------
// spg_back
// Back pipeline: three CORDIC passes, selection of the normal angle,
// projections and gap, with the output register at the end.
// ----------------------------------------------------------------------------
module spg_back #(
  parameter int CORDIC_STEPS = spg_pkg::CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [16:0]        eps,
  input  spg_pkg::item_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] gap,
  output logic signed [17:0] nx,
  output logic signed [17:0] ny
);
  import spg_pkg::*;

  localparam int L   = PRE_STAGES + CORDIC_STEPS;
  localparam int TOT = 3 * L + 8;

  logic           adv;
  logic [TOT-1:0] vld;

  assign adv = !out_valid || out_ready;
  assign pop = adv && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[TOT-2:0], pop};
    end
  end

  function automatic logic signed [17:0] unit_round(input cw_t v);
    logic [CW-1:0] m, r, s;
    m = v[CW-1] ? CW'(-v) : CW'(v);
    r = (m + CW'(8192)) >> 14;
    if (r > CW'(65536)) begin
      r = CW'(65536);
    end
    s = v[CW-1] ? (~r + 1'b1) : r;
    return s[17:0];
  endfunction

  function automatic logic [31:0] abs32(input cw_t v);
    logic [CW-1:0] m;
    m = v[CW-1] ? CW'(-v) : CW'(v);
    return m[31:0];
  endfunction

  function automatic logic [31:0] rnd30(input logic [61:0] p);
    logic [62:0] t;
    t = 63'(p) + 63'(64'd536870912);
    return t[61:30];
  endfunction

  // ---- first pass: box-frame rotation and centre direction ----
  ctx_t c1 [L];
  ctx_t n0;
  cw_t  ra_x, ra_y, ra_z, va_x, va_y, va_z;

  always_comb begin
    n0    = '0;
    n0.it = head;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c1[0] <= n0;
      for (int i = 1; i < L; i++) begin
        c1[i] <= c1[i-1];
      end
    end
  end

  spg_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_a (
    .clk(clk), .en(adv),
    .x_in({{(CW-33){head.dx[32]}}, head.dx}),
    .y_in({{(CW-33){head.dy[32]}}, head.dy}),
    .z_in(-to_q30(head.q)),
    .x_out(ra_x), .y_out(ra_y), .z_out(ra_z)
  );

  spg_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec_a (
    .clk(clk), .en(adv),
    .x_in({{(CW-33){head.dx[32]}}, head.dx}),
    .y_in({{(CW-33){head.dy[32]}}, head.dy}),
    .z_in('0),
    .x_out(va_x), .y_out(va_y), .z_out(va_z)
  );

  // ---- gain removal ----
  ctx_t c2 [2];
  ctx_t n2;
  cw_t  lx, ly, la;

  always_comb begin
    n2       = c1[L-1];
    n2.ang_a = va_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2[0] <= n2;
      c2[1] <= c2[0];
    end
  end

  spg_gain u_gain_x (.clk(clk), .en(adv), .v_in(ra_x), .v_out(lx));
  spg_gain u_gain_y (.clk(clk), .en(adv), .v_in(ra_y), .v_out(ly));
  spg_gain u_gain_l (.clk(clk), .en(adv), .v_in(va_x), .v_out(la));

  // ---- offset from the closest box point ----
  ctx_t c3, n3;
  cw_t  ex, ey, hxe, hye, clx, cly;

  assign hxe = {{(CW-30){1'b0}}, c2[1].it.hx};
  assign hye = {{(CW-30){1'b0}}, c2[1].it.hy};
  assign clx = (lx > hxe) ? hxe : ((lx < -hxe) ? -hxe : lx);
  assign cly = (ly > hye) ? hye : ((ly < -hye) ? -hye : ly);

  always_comb begin
    n3       = c2[1];
    n3.len_a = la;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c3 <= n3;
      ex <= lx - clx;
      ey <= ly - cly;
    end
  end

  // ---- second pass: length and angle of that offset ----
  ctx_t c4 [L];
  cw_t  vb_x, vb_y, vb_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      c4[0] <= c3;
      for (int i = 1; i < L; i++) begin
        c4[i] <= c4[i-1];
      end
    end
  end

  spg_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b1)) u_vec_b (
    .clk(clk), .en(adv),
    .x_in(ex), .y_in(ey), .z_in('0),
    .x_out(vb_x), .y_out(vb_y), .z_out(vb_z)
  );

  ctx_t c5 [2];
  ctx_t n5;
  cw_t  dlen;

  always_comb begin
    n5    = c4[L-1];
    n5.zl = vb_z;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c5[0] <= n5;
      c5[1] <= c5[0];
    end
  end

  spg_gain u_gain_d (.clk(clk), .en(adv), .v_in(vb_x), .v_out(dlen));

  // ---- choose normal angle and gap base ----
  ctx_t c6, n6;
  cw_t  eps_c;
  logic big_a, big_d;

  assign eps_c = {{(CW-17){1'b0}}, eps};
  assign big_a = c5[1].len_a > eps_c;
  assign big_d = dlen > eps_c;

  always_comb begin
    n6       = c5[1];
    n6.dflt  = 1'b0;
    n6.ang_p = '0;
    n6.ang_u = c5[1].ang_a;
    n6.gbase = {{(GW-2-CW){c5[1].len_a[CW-1]}}, c5[1].len_a}
             - {{(GW-34){1'b0}}, c5[1].it.rsum};
    case (c5[1].it.mode)
      MODE_BC, MODE_CB: begin
        n6.gbase = {{(GW-2-CW){dlen[CW-1]}}, dlen} - {{(GW-34){1'b0}}, c5[1].it.rsum};
        if (big_d) begin
          n6.ang_u = c5[1].zl + to_q30(c5[1].it.q);
        end else if (!big_a) begin
          // circle centre on the box centre too
          n6.dflt = 1'b1;
        end
      end
      MODE_BB: begin
        n6.dflt  = !big_a;
        n6.ang_p = big_a ? c5[1].ang_a : '0;
        n6.gbase = {{(GW-2-CW){c5[1].len_a[CW-1]}}, c5[1].len_a};
      end
      default: begin
        n6.dflt = !big_a;
      end
    endcase
  end

  ctx_t c7;
  cw_t  zpa, zpb;

  always_ff @(posedge clk) begin
    if (adv) begin
      c6  <= n6;
      c7  <= c6;
      zpa <= c6.ang_p - to_q30(c6.it.aq);
      zpb <= c6.ang_p - to_q30(c6.it.bq);
    end
  end

  // ---- third pass: unit normal and box projections ----
  ctx_t c8 [L];
  cw_t  u_x, u_y, u_z, pa_c, pa_s, pa_z, pb_c, pb_s, pb_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      c8[0] <= c7;
      for (int i = 1; i < L; i++) begin
        c8[i] <= c8[i-1];
      end
    end
  end

  spg_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_u (
    .clk(clk), .en(adv), .x_in(INV_GAIN_Q30), .y_in('0), .z_in(c7.ang_u),
    .x_out(u_x), .y_out(u_y), .z_out(u_z)
  );
  spg_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_pa (
    .clk(clk), .en(adv), .x_in(INV_GAIN_Q30), .y_in('0), .z_in(zpa),
    .x_out(pa_c), .y_out(pa_s), .z_out(pa_z)
  );
  spg_cordic #(.STEPS(CORDIC_STEPS), .VECTOR(1'b0)) u_rot_pb (
    .clk(clk), .en(adv), .x_in(INV_GAIN_Q30), .y_in('0), .z_in(zpb),
    .x_out(pb_c), .y_out(pb_s), .z_out(pb_z)
  );

  ctx_t        c9, n9;
  logic [61:0] p_ac, p_as, p_bc, p_bs;

  always_comb begin
    n9 = c8[L-1];
    if (c8[L-1].dflt) begin
      n9.nx = 18'sd65536;
      n9.ny = '0;
    end else begin
      n9.nx = unit_round(u_x);
      n9.ny = unit_round(u_y);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c9   <= n9;
      p_ac <= c8[L-1].it.ahw * abs32(pa_c);
      p_as <= c8[L-1].it.ahh * abs32(pa_s);
      p_bc <= c8[L-1].it.bhw * abs32(pb_c);
      p_bs <= c8[L-1].it.bhh * abs32(pb_s);
    end
  end

  // ---- gap, saturation and output word ----
  logic [33:0]          psum;
  logic signed [GW-1:0] gfull;
  logic signed [31:0]   gsat;

  assign psum  = 34'(rnd30(p_ac)) + 34'(rnd30(p_as)) + 34'(rnd30(p_bc)) + 34'(rnd30(p_bs));
  assign gfull = {{2{c9.gbase[GW-3]}}, c9.gbase}
               - ((c9.it.mode == MODE_BB) ? {{(GW-34){1'b0}}, psum} : '0);

  always_comb begin
    if (gfull > GW'(64'sd2147483647)) begin
      gsat = 32'sh7fffffff;
    end else if (gfull < -GW'(64'sd2147483648)) begin
      gsat = 32'sh80000000;
    end else begin
      gsat = gfull[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= vld[TOT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      gap <= gsat;
      nx  <= (c9.it.mode == MODE_CB) ? -c9.nx : c9.nx;
      ny  <= (c9.it.mode == MODE_CB) ? -c9.ny : c9.ny;
    end
  end

`ifndef NO_ASSERTIONS
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld)) else $error("pipeline moved while stalled");
  a_no_pop_stalled: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !pop) else $error("queue popped while stalled");
  a_normal_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (nx <= 18'sd65536) && (nx >= -18'sd65536)
                  && (ny <= 18'sd65536) && (ny >= -18'sd65536))
    else $error("normal out of range");
`endif

endmodule

### rtl/core/shape_pair_gap_and_normal.sv
// ----------------------------------------------------------------------------
// shape_pair_gap_and_normal
// Signed gap and unit contact normal of a 2D circle/box shape pair.
// ----------------------------------------------------------------------------
// Three CORDIC passes run in series from accept to result (direction,
// box-frame offset, normal). Throughput: one pair per cycle unless the output
// stalls; every stage is pipelined and the queue lets input be taken while a
// result waits on the output register.
// Reset: synchronous, clears queue, pipeline and output valids; epsilon to 1.
module shape_pair_gap_and_normal #(
  parameter int CORDIC_STEPS = spg_pkg::CORDIC_STEPS_DEF,
  parameter int QUEUE_DEPTH  = spg_pkg::QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [16:0]  cfg_wdata,     // length_epsilon
  input  logic         s_tvalid,
  output logic         s_tready,
  // first_pos_x, first_pos_y, first_angle, first_size_x, first_size_y,
  // second_pos_x, second_pos_y, second_angle, second_size_x, second_size_y
  input  logic [295:0] s_tdata,
  input  logic [1:0]   s_tuser,       // mode
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [71:0]  m_tdata        // gap, normal_x, normal_y
);
  import spg_pkg::*;

  logic [16:0]        eps;
  logic               full, empty, push, pop;
  item_t              item, head;
  logic signed [31:0] gap;
  logic signed [17:0] nx, ny;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps <= 17'd1;
    end else if (cfg_we) begin
      eps <= cfg_wdata;
    end
  end

  spg_front u_front (
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .full(full), .push(push), .item(item)
  );

  spg_fifo #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rst(rst), .wr(push), .wdata(item), .rd(pop), .rdata(head),
    .full(full), .empty(empty)
  );

  spg_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk(clk), .rst(rst), .eps(eps), .head(head), .head_valid(!empty), .pop(pop),
    .out_valid(m_tvalid), .out_ready(m_tready), .gap(gap), .nx(nx), .ny(ny)
  );

  assign m_tdata = {4'd0, ny, nx, gap};

endmodule

### bench/tb_shape_pair_gap_and_normal.sv
// ----------------------------------------------------------------------------
// tb_shape_pair_gap_and_normal
// Self-checking bench for the shape pair gap block: directed and random pairs
// in all four pair kinds, under several epsilon settings and idling patterns,
// with each output word checked against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_shape_pair_gap_and_normal;
  timeunit 1ns;
  timeprecision 1ps;
  import spg_pkg::*;

  localparam int  STEPS      = CORDIC_STEPS_DEF;
  localparam int  LATENCY    = 3 * STEPS + 21;
  localparam int  CYCLE_CAP  = 2000000;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint UNIT_Q30 = 64'sd652032874;
  localparam longint GAIN_Q32 = 64'd2608131496;
  localparam longint ONE = 64'sd65536;

  typedef struct {
    logic [1:0]         mode;
    logic signed [31:0] ax, ay;
    logic signed [18:0] aq;
    logic [30:0]        asx, asy;
    logic signed [31:0] bx, by;
    logic signed [18:0] bq;
    logic [30:0]        bsx, bsy;
  } pair_t;

  typedef struct {
    logic signed [31:0] gap;
    logic signed [17:0] nx, ny;
  } contact_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [16:0]  cfg_wdata = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [295:0] s_tdata = '0;
  logic [1:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;

  contact_t contacts_due[$];
  longint   eps_now = 1;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  bit       recv_hold = 0;
  int       mismatches = 0;
  int       cycles = 0;

  shape_pair_gap_and_normal i_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // ---------------- predictor ----------------
  function automatic longint rnd_shift(longint v, int s);
    longint m, r;
    m = v < 0 ? -v : v;
    r = (m + (64'sd1 <<< (s - 1))) >>> s;
    return v < 0 ? -r : r;
  endfunction

  function automatic longint gain_fix(longint v);
    longint unsigned m, r;
    m = v < 0 ? -v : v;
    r = ((m >> 16) * GAIN_Q32 + (((m & 64'hFFFF) * GAIN_Q32) >> 16) + 64'h8000) >> 16;
    return v < 0 ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic void rotate(inout longint x, inout longint y, input longint z);
    longint t, xs, ys;
    for (int k = 0; k < 4; k++) begin
      if (z > HALF_PI) begin
        t = x; x = -y; y = t; z -= HALF_PI;
      end else if (z < -HALF_PI) begin
        t = x; x = y; y = -t; z += HALF_PI;
      end
    end
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= longint'(atan_q30(i));
      end else begin
        x += ys; y -= xs; z += longint'(atan_q30(i));
      end
    end
  endfunction

  function automatic void vectorise(input longint x, input longint y,
                                    output longint mag, output longint ang);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -HALF_PI;
      end
    end
    for (int i = 0; i < STEPS && i < ATAN_ENTRIES; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x += ys; y -= xs; z += longint'(atan_q30(i));
      end else begin
        x -= ys; y += xs; z -= longint'(atan_q30(i));
      end
    end
    mag = gain_fix(x);
    ang = z;
  endfunction

  function automatic void unit_vec(input longint z, output longint nx, output longint ny);
    longint x, y;
    x = UNIT_Q30;
    y = 0;
    rotate(x, y, z);
    nx = clip(rnd_shift(x, 14), -ONE, ONE);
    ny = clip(rnd_shift(y, 14), -ONE, ONE);
  endfunction

  function automatic void heading(input longint dx, input longint dy, output longint len,
                                  output longint ang, output longint nx, output longint ny);
    longint a;
    vectorise(dx, dy, len, a);
    if (len > eps_now) begin
      ang = a;
      unit_vec(a, nx, ny);
    end else begin
      ang = 0; nx = ONE; ny = 0;
    end
  endfunction

  function automatic void box_vs_circle(input longint bx, by, bq, bw, bh, cx, cy, cr,
                                        output longint gap, nx, ny);
    longint rx, ry, lx, ly, hx, hy, d, zl, l0, a0;
    rx = cx - bx; ry = cy - by;
    lx = rx; ly = ry; hx = bw >>> 1; hy = bh >>> 1;
    rotate(lx, ly, -bq);
    lx = gain_fix(lx);
    ly = gain_fix(ly);
    vectorise(lx - clip(lx, -hx, hx), ly - clip(ly, -hy, hy), d, zl);
    if (d > eps_now) unit_vec(zl + bq, nx, ny);
    else heading(rx, ry, l0, a0, nx, ny);
    gap = d - cr;
  endfunction

  function automatic longint box_extent(longint hw, longint hh, longint z);
    longint c, s;
    c = UNIT_Q30;
    s = 0;
    rotate(c, s, z);
    if (c < 0) c = -c;
    if (s < 0) s = -s;
    return rnd_shift(hw * c, 30) + rnd_shift(hh * s, 30);
  endfunction

  function automatic contact_t predict_contact(pair_t p);
    longint ax, ay, aq, asx, asy, bx, by, bq, bsx, bsy, gap, nx, ny, len, ang;
    contact_t r;
    ax = p.ax; ay = p.ay; aq = longint'(p.aq) * 16384;
    asx = longint'({1'b0, p.asx}); asy = longint'({1'b0, p.asy});
    bx = p.bx; by = p.by; bq = longint'(p.bq) * 16384;
    bsx = longint'({1'b0, p.bsx}); bsy = longint'({1'b0, p.bsy});
    case (p.mode)
      MODE_CC: begin
        heading(bx - ax, by - ay, len, ang, nx, ny);
        gap = len - (asx + bsx);
      end
      MODE_BC: box_vs_circle(ax, ay, aq, asx, asy, bx, by, bsx, gap, nx, ny);
      MODE_CB: begin
        box_vs_circle(bx, by, bq, bsx, bsy, ax, ay, asx, gap, nx, ny);
        nx = -nx;
        ny = -ny;
      end
      default: begin
        heading(bx - ax, by - ay, len, ang, nx, ny);
        gap = len - (box_extent(asx >>> 1, asy >>> 1, ang - aq)
                     + box_extent(bsx >>> 1, bsy >>> 1, ang - bq));
      end
    endcase
    r.gap = 32'(clip(gap, -64'sd2147483648, 64'sd2147483647));
    r.nx = 18'(nx);
    r.ny = 18'(ny);
    return r;
  endfunction

  // ---------------- stimulus helpers ----------------
  function automatic logic signed [18:0] rand_angle();
    return 19'(int'($urandom_range(411774)) - 205887);
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    int kind;
    logic signed [31:0] cx, cy;
    kind = $urandom_range(9);
    p.mode = 2'($urandom_range(3));
    p.aq = rand_angle();
    p.bq = rand_angle();
    cx = 32'(int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
    cy = 32'(int'($urandom_range(32'h7FFF_FFFF)) - 32'sh4000_0000);
    p.ax = cx; p.ay = cy;
    p.bx = cx + 32'(int'($urandom_range(32'h7F_FFFF)) - 32'sh40_0000);
    p.by = cy + 32'(int'($urandom_range(32'h7F_FFFF)) - 32'sh40_0000);
    p.asx = 31'($urandom_range(32'h3F_FFFF)); p.asy = 31'($urandom_range(32'h3F_FFFF));
    p.bsx = 31'($urandom_range(32'h3F_FFFF)); p.bsy = 31'($urandom_range(32'h3F_FFFF));
    case (kind)
      6: begin
        p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
        p.asx = 31'($urandom); p.asy = 31'($urandom);
        p.bsx = 31'($urandom); p.bsy = 31'($urandom);
      end
      7: begin
        // centres coincide or sit a hair apart
        p.bx = p.ax + 32'($urandom_range(3)) - 32'sd1;
        p.by = p.ay + 32'($urandom_range(3)) - 32'sd1;
      end
      8: begin
        p.asx = 31'h7FFF_FFFF - 31'($urandom_range(255));
        p.bsx = 31'h7FFF_FFFF - 31'($urandom_range(255));
        p.asy = 31'($urandom); p.bsy = 31'($urandom);
      end
      9: begin
        // circle centre well inside the box
        p.asx = 31'h100_0000; p.asy = 31'h100_0000;
        p.bsx = 31'h100_0000; p.bsy = 31'h100_0000;
        p.bx = p.ax + 32'(int'($urandom_range(32'hF_FFFF)) - 32'sh8_0000);
        p.by = p.ay + 32'(int'($urandom_range(32'hF_FFFF)) - 32'sh8_0000);
      end
      default: ;
    endcase
    return p;
  endfunction

  function automatic pair_t make_pair(logic [1:0] m, int ax, int ay, int aq, int asx, int asy,
                                      int bx, int by, int bq, int bsx, int bsy);
    pair_t p;
    p.mode = m; p.ax = ax; p.ay = ay; p.aq = 19'(aq); p.asx = 31'(asx); p.asy = 31'(asy);
    p.bx = bx; p.by = by; p.bq = 19'(bq); p.bsx = 31'(bsx); p.bsy = 31'(bsy);
    return p;
  endfunction

  task automatic send_pair(pair_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= p.mode;
    s_tdata <= {6'd0, p.bsy, p.bsx, p.bq, p.by, p.bx, p.asy, p.asx, p.aq, p.ay, p.ax};
    do @(posedge clk); while (!s_tready);
    contacts_due.push_back(predict_contact(p));
  endtask

  task automatic end_burst();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (contacts_due.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_epsilon(logic [16:0] v);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    eps_now = v;
  endtask

  task automatic send_random(int n);
    repeat (n) send_pair(rand_pair());
    end_burst();
  endtask

  // ---------------- tests ----------------
  task automatic test_directed();
    int big;
    big = 32'h7FFF_FFFF;
    send_idle_pct = 0; recv_stall_pct = 0;
    send_pair(make_pair(MODE_CC, 0, 0, 0, 65536, 0, 196608, 0, 0, 65536, 0));
    send_pair(make_pair(MODE_CC, 100, 100, 0, 1, 0, 100, 100, 0, 1, 0));
    send_pair(make_pair(MODE_CC, 0, 0, 0, big, big, 0, 0, 0, big, big));
    send_pair(make_pair(MODE_CC, -big - 1, -big - 1, 0, 0, 0, big, big, 0, 0, 0));
    send_pair(make_pair(MODE_BC, 0, 0, 51472, 262144, 131072, 300000, 200000, 0, 65536, 0));
    send_pair(make_pair(MODE_BC, 0, 0, 0, 262144, 262144, 1000, 0, 0, 65536, 0));
    send_pair(make_pair(MODE_BC, 5, 5, 0, 262144, 262144, 5, 5, 0, 65536, 0));
    send_pair(make_pair(MODE_BC, 0, 0, 205887, big, big, big, -big - 1, 0, big, 0));
    send_pair(make_pair(MODE_CB, 300000, 200000, 0, 65536, 0, 0, 0, -51472, 262144, 131072));
    send_pair(make_pair(MODE_CB, 7, -7, 0, 65536, 0, 7, -7, 0, 262144, 262144));
    send_pair(make_pair(MODE_CB, 0, 0, 0, 0, 0, 0, 0, -205887, big, big));
    send_pair(make_pair(MODE_BB, 0, 0, 0, 131072, 131072, 300000, 0, 0, 131072, 131072));
    send_pair(make_pair(MODE_BB, 0, 0, 25736, 131072, 65536, 0, 0, -25736, 131072, 65536));
    send_pair(make_pair(MODE_BB, 0, 0, 205887, big, big, 1, 1, -205887, big, big));
    send_pair(make_pair(MODE_BB, -big - 1, big, -205887, 0, 0, big, -big - 1, 205887, 0, 0));
    send_pair(make_pair(MODE_CC, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0));
    end_burst();
    set_epsilon(17'd0);
    send_pair(make_pair(MODE_CC, 3, 3, 0, 65536, 0, 3, 3, 0, 65536, 0));
    send_pair(make_pair(MODE_BC, 0, 0, 0, 262144, 262144, 0, 0, 0, 65536, 0));
    send_pair(make_pair(MODE_CC, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    end_burst();
    set_epsilon(17'd65536);
    send_pair(make_pair(MODE_CC, 0, 0, 0, 0, 0, 65536, 0, 0, 0, 0));
    send_pair(make_pair(MODE_CC, 0, 0, 0, 0, 0, 65537, 0, 0, 0, 0));
    send_pair(make_pair(MODE_BB, 0, 0, 0, 65536, 65536, 30000, 30000, 0, 65536, 65536));
    send_pair(make_pair(MODE_CB, 0, 0, 0, 65536, 0, 0, 40000, 0, 262144, 262144));
    end_burst();
  endtask

  task automatic test_no_idling();
    set_epsilon(17'd1);
    send_idle_pct = 0; recv_stall_pct = 0;
    send_random(300);
  endtask

  task automatic test_sender_idle();
    set_epsilon(17'd0);
    send_idle_pct = 86; recv_stall_pct = 0;
    send_random(250);
  endtask

  task automatic test_receiver_stall();
    set_epsilon(17'd65536);
    send_idle_pct = 0; recv_stall_pct = 86;
    send_random(250);
  endtask

  task automatic test_both_idle();
    set_epsilon(17'($urandom_range(65536)));
    send_idle_pct = 6; recv_stall_pct = 6;
    send_random(250);
  endtask

  // receiver holds off long enough for the queue and pipeline to fill
  task automatic test_backpressure();
    set_epsilon(17'($urandom_range(1023)));
    send_idle_pct = 0; recv_stall_pct = 0;
    recv_hold = 1;
    fork
      begin
        int held;
        held = 0;
        while (held < 400) begin
          @(posedge clk);
          held++;
        end
        recv_hold = 0;
      end
      send_random(150);
    join
    // sender pauses until every word is back, then resumes
    while (contacts_due.size() != 0) @(posedge clk);
    send_idle_pct = 30; recv_stall_pct = 30;
    send_random(120);
  endtask

  // ---------------- receiver and checker ----------------
  always @(posedge clk) begin
    m_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    contact_t want, got;
    if (!rst && m_tvalid && m_tready) begin
      got.gap = m_tdata[31:0];
      got.nx = m_tdata[49:32];
      got.ny = m_tdata[67:50];
      if (contacts_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: gap %0d nx %0d ny %0d",
                                       got.gap, got.nx, got.ny);
      end else begin
        want = contacts_due.pop_front();
        if (got.gap !== want.gap || got.nx !== want.nx || got.ny !== want.ny) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: gap %0d/%0d nx %0d/%0d ny %0d/%0d (expected/actual)",
                     want.gap, got.gap, want.nx, got.nx, want.ny, got.ny);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_no_idling();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    wait_drained();
    if (mismatches == 0 && contacts_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
